>>> rtl/core/ippp_pkg.sv
package ippp_pkg;

    // Field widths of the stream items and configuration registers.
    localparam int SAMPLE_W = 12;
    localparam int POS_W    = 16;
    localparam int ERR_W    = 17;
    localparam int PW_W     = 10;
    localparam int GAIN_W   = 32;
    localparam int BIAS_W   = 16;
    localparam int CFG_IDX_W = 3;

    // Datapath widths: one shared signed multiplier and the accumulator.
    localparam int DIST_W     = 9;
    localparam int RECIP_W    = 28;
    localparam int MUL_A_W    = 33;
    localparam int MUL_B_W    = 18;
    localparam int MUL_P_W    = 51;
    localparam int ACC_W      = 52;
    localparam int ACC_SPLIT  = 26;
    localparam int LO_PROD_W  = 37;
    localparam int PROD_W     = 62;
    localparam int POS_SHIFT  = 19;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_BIAS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE  = 3'd4;

    // Register reset values.
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 32'd52429;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 32'd26;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 32'd0;
    localparam logic [BIAS_W-1:0] DUTY_BIAS_RST  = 16'd22938;
    localparam logic [PW_W-1:0]   MAX_PULSE_RST  = 10'd900;

    // Sensor linearization breakpoints.
    localparam logic [SAMPLE_W-1:0] SAMPLE_ZERO_ABOVE = 12'd2000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_ONE_BELOW  = 12'd1500;
    localparam logic [SAMPLE_W-1:0] SAMPLE_KNEE       = 12'd1950;
    localparam logic [POS_W-1:0]    POS_ONE           = 16'd32768;

    // Position is d * 2^15 / span with d = 2000 - sample. With
    // recip = ceil(2^34 / span) this equals (d * recip) >> 19 exactly for d <= 500.
    localparam logic [RECIP_W-1:0] RECIP_NEAR = 28'd171798692; // span of 100
    localparam logic [RECIP_W-1:0] RECIP_FAR  = 28'd34359739;  // span of 500

    typedef logic [3:0] t_step;

    localparam t_step STEP_IDLE  = 4'd0;
    localparam t_step STEP_LIN   = 4'd1;
    localparam t_step STEP_POS   = 4'd2;
    localparam t_step STEP_MULP  = 4'd3;
    localparam t_step STEP_MULD  = 4'd4;
    localparam t_step STEP_MULI  = 4'd5;
    localparam t_step STEP_SUMI  = 4'd6;
    localparam t_step STEP_SCLO  = 4'd7;
    localparam t_step STEP_SCHI  = 4'd8;
    localparam t_step STEP_FIN   = 4'd9;

    typedef enum logic [2:0] {
        MA_RECIP,
        MA_KP,
        MA_KD,
        MA_KI,
        MA_ACC_LO,
        MA_ACC_HI
    } t_mul_a;

    typedef enum logic [2:0] {
        MB_DIST,
        MB_ERR,
        MB_DIFF,
        MB_SUM,
        MB_MPW
    } t_mul_b;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_BIAS_P,
        ACC_ADD_P
    } t_acc_op;

    typedef enum logic [1:0] {
        COND_NEXT,
        COND_NO_IN,
        COND_OUT_FULL,
        COND_ALWAYS
    } t_cond;

    // One control word of the sequencer program.
    typedef struct packed {
        logic    idle;
        t_mul_a  a_sel;
        t_mul_b  b_sel;
        t_acc_op acc_op;
        logic    ld_pos;
        logic    ld_lo;
        logic    fin;
        logic    last;
        t_cond   cond;
        t_step   target;
    } t_uword;

    // Datapath controls issued by the sequencer each cycle.
    typedef struct packed {
        t_mul_a  a_sel;
        t_mul_b  b_sel;
        t_acc_op acc_op;
        logic    ld_in;
        logic    ld_pos;
        logic    ld_lo;
        logic    wr_out;
    } t_ctrl;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] deriv_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [BIAS_W-1:0] duty_bias;
        logic [PW_W-1:0]   max_pulse_width;
    } t_cfg;

    typedef struct packed {
        logic                    clamped;
        logic signed [ERR_W-1:0] error_value;
        logic [POS_W-1:0]        position_norm;
        logic [PW_W-1:0]         pulse_width;
    } t_result;

    localparam t_uword UW_NOP = '{
        idle:   1'b0,
        a_sel:  MA_KP,
        b_sel:  MB_ERR,
        acc_op: ACC_HOLD,
        ld_pos: 1'b0,
        ld_lo:  1'b0,
        fin:    1'b0,
        last:   1'b0,
        cond:   COND_NEXT,
        target: STEP_IDLE
    };

    // Control program: linearize, three gain products, then scale by the
    // pulse width limit in two halves of the accumulator.
    function automatic t_uword ucode_rom(input t_step step);
        t_uword w;
        w = UW_NOP;
        case (step)
            STEP_IDLE: begin
                w.idle   = 1'b1;
                w.cond   = COND_NO_IN;
                w.target = STEP_IDLE;
            end
            STEP_LIN: begin
                w.a_sel = MA_RECIP;
                w.b_sel = MB_DIST;
            end
            STEP_POS: begin
                w.ld_pos = 1'b1;
            end
            STEP_MULP: begin
                w.a_sel = MA_KP;
                w.b_sel = MB_ERR;
            end
            STEP_MULD: begin
                w.a_sel  = MA_KD;
                w.b_sel  = MB_DIFF;
                w.acc_op = ACC_BIAS_P;
            end
            STEP_MULI: begin
                w.a_sel  = MA_KI;
                w.b_sel  = MB_SUM;
                w.acc_op = ACC_ADD_P;
            end
            STEP_SUMI: begin
                w.acc_op = ACC_ADD_P;
            end
            STEP_SCLO: begin
                w.a_sel = MA_ACC_LO;
                w.b_sel = MB_MPW;
            end
            STEP_SCHI: begin
                w.a_sel = MA_ACC_HI;
                w.b_sel = MB_MPW;
                w.ld_lo = 1'b1;
            end
            STEP_FIN: begin
                // Keep the upper scaled product in place while the result waits.
                w.a_sel  = MA_ACC_HI;
                w.b_sel  = MB_MPW;
                w.fin    = 1'b1;
                w.last   = 1'b1;
                w.cond   = COND_OUT_FULL;
                w.target = STEP_FIN;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/ippp_seq.sv
module ippp_seq
    import ippp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_full,
    output logic  o_in_ready,
    output t_ctrl o_ctrl
);

    t_step  r_step;
    t_step  n_step;
    t_uword w_word;
    logic   w_jump;

    // Fetch the control word of the current step.
    assign w_word = ucode_rom(r_step);

    // Evaluate the jump condition and pick the next step.
    always_comb begin
        case (w_word.cond)
            COND_NEXT:     w_jump = 1'b0;
            COND_NO_IN:    w_jump = !i_in_valid;
            COND_OUT_FULL: w_jump = i_out_full;
            COND_ALWAYS:   w_jump = 1'b1;
            default:       w_jump = 1'b1;
        endcase
        if (w_jump) begin
            n_step = w_word.target;
        end else if (w_word.last) begin
            n_step = STEP_IDLE;
        end else begin
            n_step = r_step + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // Decode the word into datapath controls.
    always_comb begin
        o_in_ready    = w_word.idle;
        o_ctrl.a_sel  = w_word.a_sel;
        o_ctrl.b_sel  = w_word.b_sel;
        o_ctrl.acc_op = w_word.acc_op;
        o_ctrl.ld_in  = w_word.idle && i_in_valid;
        o_ctrl.ld_pos = w_word.ld_pos;
        o_ctrl.ld_lo  = w_word.ld_lo;
        o_ctrl.wr_out = w_word.fin && !i_out_full;
    end

endmodule

>>> rtl/core/ippp_datapath.sv
module ippp_datapath
    import ippp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctrl               i_ctrl,
    input  t_cfg                i_cfg,
    input  logic [SAMPLE_W-1:0] i_ir_sample,
    input  logic [POS_W-1:0]    i_setpoint,
    output t_result             o_result
);

    logic [SAMPLE_W-1:0]      r_sample;
    logic [POS_W-1:0]         r_setpoint;
    logic signed [MUL_P_W-1:0] r_prod;
    logic [POS_W-1:0]         r_pos;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [ERR_W-1:0]  r_prev;
    logic signed [MUL_B_W-1:0] r_diff;
    logic signed [MUL_B_W-1:0] r_sum;
    logic signed [ACC_W-1:0]  r_acc;
    logic [LO_PROD_W-1:0]     r_lo_prod;

    logic [SAMPLE_W-1:0]       w_dist_full;
    logic [DIST_W-1:0]         w_dist;
    logic [RECIP_W-1:0]        w_recip;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [MUL_P_W-1:0] w_mul_p;
    logic [POS_W-1:0]          w_pos;
    logic signed [ERR_W-1:0]   w_err;
    logic signed [ACC_W-1:0]   w_prod_ext;
    logic signed [ACC_W-1:0]   w_bias_ext;
    logic signed [PROD_W-1:0]  w_scaled;
    logic                      w_neg_clamp;
    logic                      w_pos_clamp;
    logic [PROD_W-33:0]        w_quot;

    // Distance below the upper breakpoint and the reciprocal of its segment.
    assign w_dist_full = SAMPLE_ZERO_ABOVE - r_sample;
    assign w_dist      = w_dist_full[DIST_W-1:0];
    assign w_recip     = (r_sample > SAMPLE_KNEE) ? RECIP_NEAR : RECIP_FAR;

    // Operand selection for the shared multiplier.
    always_comb begin
        case (i_ctrl.a_sel)
            MA_RECIP:  w_mul_a = $signed({5'b0, w_recip});
            MA_KP:     w_mul_a = $signed({i_cfg.prop_gain[GAIN_W-1], i_cfg.prop_gain});
            MA_KD:     w_mul_a = $signed({i_cfg.deriv_gain[GAIN_W-1], i_cfg.deriv_gain});
            MA_KI:     w_mul_a = $signed({i_cfg.integ_gain[GAIN_W-1], i_cfg.integ_gain});
            MA_ACC_LO: w_mul_a = $signed({7'b0, r_acc[ACC_SPLIT-1:0]});
            MA_ACC_HI: w_mul_a = $signed({{7{r_acc[ACC_W-1]}}, r_acc[ACC_W-1:ACC_SPLIT]});
            default:   w_mul_a = '0;
        endcase
        case (i_ctrl.b_sel)
            MB_DIST: w_mul_b = $signed({9'b0, w_dist});
            MB_ERR:  w_mul_b = $signed({r_err[ERR_W-1], r_err});
            MB_DIFF: w_mul_b = r_diff;
            MB_SUM:  w_mul_b = r_sum;
            MB_MPW:  w_mul_b = $signed({8'b0, i_cfg.max_pulse_width});
            default: w_mul_b = '0;
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    // Piecewise position and the control error.
    always_comb begin
        if (r_sample > SAMPLE_ZERO_ABOVE) begin
            w_pos = '0;
        end else if (r_sample < SAMPLE_ONE_BELOW) begin
            w_pos = POS_ONE;
        end else begin
            w_pos = r_prod[POS_SHIFT+POS_W-1:POS_SHIFT];
        end
        w_err = $signed({1'b0, r_setpoint}) - $signed({1'b0, w_pos});
    end

    // Accumulator operands.
    assign w_prod_ext = $signed({{(ACC_W-MUL_P_W){r_prod[MUL_P_W-1]}}, r_prod});
    assign w_bias_ext = $signed({20'b0, i_cfg.duty_bias, 16'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_ctrl.ld_pos) begin
            r_prev <= w_err;
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_p;
        if (i_ctrl.ld_in) begin
            r_sample   <= i_ir_sample;
            r_setpoint <= i_setpoint;
        end
        if (i_ctrl.ld_pos) begin
            r_pos  <= w_pos;
            r_err  <= w_err;
            r_diff <= $signed({w_err[ERR_W-1], w_err}) - $signed({r_prev[ERR_W-1], r_prev});
            r_sum  <= $signed({w_err[ERR_W-1], w_err}) + $signed({r_prev[ERR_W-1], r_prev});
        end
        case (i_ctrl.acc_op)
            ACC_BIAS_P: r_acc <= w_bias_ext + w_prod_ext;
            ACC_ADD_P:  r_acc <= r_acc + w_prod_ext;
            default:    r_acc <= r_acc;
        endcase
        if (i_ctrl.ld_lo) begin
            r_lo_prod <= r_prod[LO_PROD_W-1:0];
        end
    end

    // Join the two scaled halves; the upper half product fits in 36 bits.
    assign w_scaled = $signed({r_prod[35:0], 26'b0}) + $signed({25'b0, r_lo_prod});

    // Truncate toward zero and clamp to the pulse width limit. A negative
    // value clamps once its magnitude reaches one whole count.
    assign w_quot      = w_scaled[PROD_W-2:31];
    assign w_neg_clamp = w_scaled[PROD_W-1] &&
                         !((&w_scaled[PROD_W-1:31]) && (|w_scaled[30:0]));
    assign w_pos_clamp = !w_scaled[PROD_W-1] && (w_quot > {20'b0, i_cfg.max_pulse_width});

    always_comb begin
        o_result.position_norm = r_pos;
        o_result.error_value   = r_err;
        o_result.clamped       = w_neg_clamp || w_pos_clamp;
        if (w_scaled[PROD_W-1]) begin
            o_result.pulse_width = '0;
        end else if (w_pos_clamp) begin
            o_result.pulse_width = i_cfg.max_pulse_width;
        end else begin
            o_result.pulse_width = w_quot[PW_W-1:0];
        end
    end

endmodule

>>> rtl/core/ir_position_pid_pwm.sv
// A result is registered in the output slot once the ten-step control program
// has run linearization, three gain products and a two-part scaling through
// one shared 33x18 multiplier; a new item is taken only after the result of
// the last one has been written to the output slot.
// Reset (synchronous, active low) restores register defaults, clears the
// previous error, returns the sequencer to idle and empties the output.
module ir_position_pid_pwm
    import ippp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GAIN_W-1:0]    i_cfg_data,
    // Input items.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,  // ir_sample[11:0], setpoint[27:12]
    // Result items.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [47:0]          m_axis_tdata   // pulse_width[9:0], position_norm[25:10],
                                                // error_value[42:26], clamped[43]
);

    t_cfg    r_cfg;
    logic    r_out_valid;
    t_result r_out;
    t_ctrl   w_ctrl;
    t_result w_result;
    logic    w_out_full;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain       <= PROP_GAIN_RST;
            r_cfg.deriv_gain      <= DERIV_GAIN_RST;
            r_cfg.integ_gain      <= INTEG_GAIN_RST;
            r_cfg.duty_bias       <= DUTY_BIAS_RST;
            r_cfg.max_pulse_width <= MAX_PULSE_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_PROP_GAIN:  r_cfg.prop_gain       <= i_cfg_data;
                REG_DERIV_GAIN: r_cfg.deriv_gain      <= i_cfg_data;
                REG_INTEG_GAIN: r_cfg.integ_gain      <= i_cfg_data;
                REG_DUTY_BIAS:  r_cfg.duty_bias       <= i_cfg_data[BIAS_W-1:0];
                REG_MAX_PULSE:  r_cfg.max_pulse_width <= i_cfg_data[PW_W-1:0];
                default:        r_cfg                 <= r_cfg;
            endcase
        end
    end

    // The output slot is full unless its item leaves in this cycle.
    assign w_out_full = r_out_valid && !m_axis_tready;

    ippp_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_full (w_out_full),
        .o_in_ready (s_axis_tready),
        .o_ctrl     (w_ctrl)
    );

    ippp_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_cfg       (r_cfg),
        .i_ir_sample (s_axis_tdata[11:0]),
        .i_setpoint  (s_axis_tdata[27:12]),
        .o_result    (w_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.wr_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.wr_out) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out.clamped, r_out.error_value,
                            r_out.position_norm, r_out.pulse_width};

    // The sequencer leaves idle right after taking an item.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready stayed high after an item was accepted");

    // A finished result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.wr_out |-> !w_out_full)
        else $error("result written into a full output slot");

    // A new result is only written while the sequencer is off idle.
    a_fin_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.wr_out |-> !s_axis_tready)
        else $error("result written while the sequencer is idle");

    // The linearized position never exceeds one.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out.position_norm <= POS_ONE))
        else $error("position out of range");

endmodule

>>> tb/pid_pwm_checker.sv
// Watches the configuration port and both item channels of the PID pulse-width
// block, predicts every result from its own copy of the registers and of the
// previous error, and compares each result with the oldest prediction.
module pid_pwm_checker
    import ippp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GAIN_W-1:0]    i_cfg_data,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [31:0]          i_s_tdata,  // ir_sample[11:0], setpoint[27:12]
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [47:0]          i_m_tdata,  // pulse_width[9:0], position_norm[25:10],
                                             // error_value[42:26], clamped[43]
    output int                   o_mismatches,
    output int                   o_pending,
    output int                   o_items,
    output int                   o_results,
    output int                   o_clamps
);

    // Spans of the two linear pieces of the sensor curve.
    localparam longint NEAR_SPAN  = 100;
    localparam longint FAR_SPAN   = 500;
    // The bias is Q1.15 and the gain products carry 31 fraction bits.
    localparam longint BIAS_ALIGN = 65536;
    localparam int     PULSE_FRAC = 31;
    localparam longint PULSE_UNIT = 64'sd2147483648;

    // Mirrored registers and loop state.
    longint  prop_gain;
    longint  deriv_gain;
    longint  integ_gain;
    longint  duty_bias;
    longint  max_pulse;
    longint  last_error;

    t_result pending_pulses[$];
    int      pending_count;
    int      mismatches;
    int      items;
    int      results;
    int      clamps;

    assign o_mismatches = mismatches;
    assign o_pending    = pending_count;
    assign o_items      = items;
    assign o_results    = results;
    assign o_clamps     = clamps;

    initial begin
        mismatches    = 0;
        pending_count = 0;
        items         = 0;
        results       = 0;
        clamps        = 0;
    end

    // Linearize the sample, run the PID law on the error and clamp the
    // scaled pulse width to the limit register.
    function automatic t_result predict_pulse(input logic [SAMPLE_W-1:0] sample,
                                              input logic [POS_W-1:0] setpoint);
        longint  position;
        longint  error;
        longint  acc;
        longint  prod;
        longint  scaled;
        longint  pulse;
        logic    clamp;
        t_result r;
        clamp = 1'b0;
        if (sample > SAMPLE_ZERO_ABOVE) begin
            position = 0;
        end else if (sample < SAMPLE_ONE_BELOW) begin
            position = POS_ONE;
        end else begin
            position = (longint'(SAMPLE_ZERO_ABOVE) - longint'(sample)) * longint'(POS_ONE)
                / ((sample > SAMPLE_KNEE) ? NEAR_SPAN : FAR_SPAN);
        end
        error = longint'(setpoint) - position;
        acc = prop_gain * error
            + deriv_gain * (error - last_error)
            + integ_gain * (error + last_error)
            + duty_bias * BIAS_ALIGN;
        prod = acc * max_pulse;
        if (prod < 0) begin
            // Truncation toward zero: only a magnitude of a whole count clamps.
            pulse = 0;
            clamp = (prod <= -PULSE_UNIT);
        end else begin
            scaled = prod >>> PULSE_FRAC;
            if (scaled > max_pulse) begin
                pulse = max_pulse;
                clamp = 1'b1;
            end else begin
                pulse = scaled;
            end
        end
        r.pulse_width   = pulse[PW_W-1:0];
        r.position_norm = position[POS_W-1:0];
        r.error_value   = error[ERR_W-1:0];
        r.clamped       = clamp;
        return r;
    endfunction

    task automatic compare_field(input string field, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // Everything is sampled at the rising edge, where handshakes complete.
    always @(posedge i_clk) begin : watch
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            prop_gain  = $signed(PROP_GAIN_RST);
            deriv_gain = $signed(DERIV_GAIN_RST);
            integ_gain = $signed(INTEG_GAIN_RST);
            duty_bias  = DUTY_BIAS_RST;
            max_pulse  = MAX_PULSE_RST;
            last_error = 0;
            pending_pulses.delete();
        end else begin
            // Register writes; unknown indexes leave everything as it is.
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_PROP_GAIN:  prop_gain  = $signed(i_cfg_data);
                    REG_DERIV_GAIN: deriv_gain = $signed(i_cfg_data);
                    REG_INTEG_GAIN: integ_gain = $signed(i_cfg_data);
                    REG_DUTY_BIAS:  duty_bias  = i_cfg_data[BIAS_W-1:0];
                    REG_MAX_PULSE:  max_pulse  = i_cfg_data[PW_W-1:0];
                    default: ;
                endcase
            end

            // Results are matched in order against the oldest prediction.
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata[$bits(t_result)-1:0]);
                results++;
                if (pending_pulses.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with no item waiting, expected none, got %h",
                             $time, got);
                end else begin
                    want = pending_pulses.pop_front();
                    compare_field("pulse_width", want.pulse_width, got.pulse_width);
                    compare_field("position_norm", want.position_norm, got.position_norm);
                    compare_field("error_value", want.error_value, got.error_value);
                    compare_field("clamped", want.clamped, got.clamped);
                end
            end

            // Each accepted item yields exactly one result.
            if (i_s_tvalid && i_s_tready) begin
                want = predict_pulse(i_s_tdata[SAMPLE_W-1:0], i_s_tdata[SAMPLE_W +: POS_W]);
                last_error = want.error_value;
                pending_pulses.push_back(want);
                items++;
                if (want.clamped) begin
                    clamps++;
                end
            end
        end
        pending_count <= pending_pulses.size();
    end

endmodule

>>> tb/tb.sv
module tb;
    import ippp_pkg::*;

    localparam int IDLE_PCT        = 15;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 85;
    localparam int NO_IDLE_PHASE   = 4;
    localparam int PRESSURE_PHASE  = 6;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int TAIL_CYCLES     = 12;
    localparam int DIRECTED_N      = 18;
    localparam int GAIN_SPREAD     = 131072;
    localparam logic [GAIN_W-1:0]    GAIN_MAX  = 32'h7FFF_FFFF;
    localparam logic [GAIN_W-1:0]    GAIN_MIN  = 32'h8000_0000;
    localparam logic [BIAS_W-1:0]    BIAS_MAX  = 16'd32768;
    localparam logic [PW_W-1:0]      PULSE_MAX = 10'd1023;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_MAX_PULSE + 3'd1;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [GAIN_W-1:0]    i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata;  // ir_sample[11:0], setpoint[27:12]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [47:0]          m_axis_tdata;  // pulse_width[9:0], position_norm[25:10],
                                         // error_value[42:26], clamped[43]

    int   mismatches;
    int   pending;
    int   items_seen;
    int   results_seen;
    int   clamps_seen;
    int   lost_results;
    int   settings_loaded;
    logic tx_idles;
    logic rx_idles;
    logic hold_req;

    // Sensor breakpoints and the extremes of the setpoint.
    int edge_sample [DIRECTED_N] = '{0, 4095, 1499, 1500, 1501, 1725, 1949, 1950, 1951,
                                     1975, 1999, 2000, 2001, 2730, 1365, 1950, 1700, 2000};
    int edge_setpoint [DIRECTED_N] = '{0, 32768, 32768, 0, 16384, 32767, 1, 21845, 26214,
                                       16384, 32768, 0, 22938, 10922, 0, 32768, 19661,
                                       32768};

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    ir_position_pid_pwm u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    pid_pwm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_items      (items_seen),
        .o_results    (results_seen),
        .o_clamps     (clamps_seen)
    );

    // Samples mostly fall on the sloped part of the sensor curve.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0, 1, 2: return SAMPLE_W'($urandom);
            default: return SAMPLE_W'($urandom_range(2020, 1480));
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_setpoint();
        case ($urandom_range(9))
            0:       return '0;
            1:       return POS_ONE;
            default: return POS_W'($urandom_range(POS_ONE));
        endcase
    endfunction

    // Gains near unity keep most pulses off the clamp; some span the full range.
    function automatic logic [GAIN_W-1:0] pick_gain();
        int g;
        case ($urandom_range(7))
            0:       g = $urandom;
            1:       g = 0;
            default: g = int'($urandom_range(2 * GAIN_SPREAD)) - GAIN_SPREAD;
        endcase
        return g;
    endfunction

    function automatic logic [PW_W-1:0] pick_pulse_max();
        case ($urandom_range(9))
            0:       return '0;
            1:       return PULSE_MAX;
            default: return PW_W'($urandom_range(PULSE_MAX, 1));
        endcase
    endfunction

    // The write enable stays high across back-to-back writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [GAIN_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    // Writes every register, then one index that does not exist.
    task automatic load_settings(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] kd,
                                 input logic [GAIN_W-1:0] ki, input logic [BIAS_W-1:0] bias,
                                 input logic [PW_W-1:0] limit);
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_DERIV_GAIN, kd);
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_DUTY_BIAS, {16'($urandom), bias});
        write_reg(REG_MAX_PULSE, {22'($urandom), limit});
        write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, REG_UNUSED_FIRST)), $urandom);
        i_cfg_wr_en <= 1'b0;
        settings_loaded++;
    endtask

    // Offers one item, with random gaps in front of it, and waits for acceptance.
    task automatic send_item(input logic [SAMPLE_W-1:0] sample,
                             input logic [POS_W-1:0] setpoint);
        while (tx_idles && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(32 - POS_W - SAMPLE_W){1'b0}}, setpoint, sample};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    // Stops offering items and waits until every predicted result has arrived.
    task automatic wait_for_results();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending != 0) begin
            lost_results += pending;
            $display("%0t: %0d expected results never arrived", $time, pending);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Result side: random back-pressure, plus one long hold when asked for.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= !(rx_idles && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Stimulus and verdict.
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        tx_idles        = 1'b1;
        rx_idles        = 1'b1;
        hold_req        = 1'b0;
        lost_results    = 0;
        settings_loaded = 1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Breakpoints and setpoint extremes under the reset settings.
        for (int k = 0; k < DIRECTED_N; k++) begin
            send_item(SAMPLE_W'(edge_sample[k]), POS_W'(edge_setpoint[k]));
        end
        wait_for_results();

        // Each phase loads new registers while idle, then runs random items.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       load_settings(GAIN_MAX, GAIN_MIN, GAIN_MAX, BIAS_MAX, PULSE_MAX);
                1:       load_settings(GAIN_MIN, GAIN_MAX, GAIN_MIN, '0, '0);
                2:       load_settings(PROP_GAIN_RST, DERIV_GAIN_RST, GAIN_SPREAD, '0,
                                       PULSE_MAX);
                default: load_settings(pick_gain(), pick_gain(), pick_gain(),
                                       BIAS_W'($urandom_range(BIAS_MAX)), pick_pulse_max());
            endcase
            tx_idles = (p != NO_IDLE_PHASE);
            rx_idles = (p != NO_IDLE_PHASE);
            if (p == PRESSURE_PHASE) begin
                hold_req = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) begin
                send_item(pick_sample(), pick_setpoint());
            end
            wait_for_results();
        end

        $display("Ran %0d items under %0d register settings, including a long output stall.",
                 items_seen, settings_loaded);
        $display("Checked %0d results, %0d of them at a clamp limit.",
                 results_seen, clamps_seen);
        if (mismatches == 0 && lost_results == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
